### hdl/http_request_line_parser_macros.svh
// Assertion macros used by the parser top-level file.
`ifndef HTTP_REQUEST_LINE_PARSER_MACROS_SVH
`define HTTP_REQUEST_LINE_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled in reset.
`define HRLP_ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("hrlp assertion failed");

// Next-cycle implication, disabled in reset.
`define HRLP_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("hrlp assertion failed");

`else

`define HRLP_ASSERT_IMPLIES(label, clk, rst, lhs, rhs)
`define HRLP_ASSERT_NEXT(label, clk, rst, lhs, rhs)

`endif

`endif

### hdl/hrlp_pkg.sv
package hrlp_pkg;

  localparam int LINE_LIMIT = 1024;
  localparam int LINE_W = $clog2(LINE_LIMIT);

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef enum logic [1:0] {
    KIND_PATH = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_VERSION = 2'd2,
    KIND_DONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    METHOD_NONE = 2'd0,
    METHOD_GET = 2'd1,
    METHOD_POST = 2'd2,
    METHOD_HEAD = 2'd3
  } method_t;

  typedef enum logic {
    STATUS_OK = 1'b0,
    STATUS_NOT_IMPL = 1'b1
  } status_t;

  typedef enum logic {
    PH_REQUEST = 1'b0,
    PH_HEADER = 1'b1
  } phase_t;

  // Classified byte handed from front to back.
  typedef struct packed {
    logic term;
    logic sep;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic [7:0] out_byte;
    status_t status;
    method_t method;
    logic has_query;
  } result_t;

  localparam int WORD_W = $bits(result_t);
  localparam int CMD_W = $bits(cmd_t);
  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

endpackage

### hdl/hrlp_fifo.sv
module hrlp_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  hrlp_pkg::word_t       wr_data,
  input  logic                  pop,
  output hrlp_pkg::word_t       rd_data,
  output hrlp_pkg::fifo_stat_t  stat
);

  hrlp_pkg::word_t entries [hrlp_pkg::FIFO_DEPTH];
  logic [hrlp_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [hrlp_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [hrlp_pkg::FIFO_CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign stat.full = (count == hrlp_pkg::FIFO_CNT_W'(hrlp_pkg::FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push = push && !stat.full;
  assign do_pop = pop && !stat.empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == hrlp_pkg::FIFO_PTR_W'(hrlp_pkg::FIFO_DEPTH - 1)) ? '0
                  : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == hrlp_pkg::FIFO_PTR_W'(hrlp_pkg::FIFO_DEPTH - 1)) ? '0
                  : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

### hdl/hrlp_front.sv
module hrlp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      data_byte,
  input  logic            push,
  output logic            full,
  input  logic            cmd_full,
  output logic            cmd_push,
  output hrlp_pkg::word_t cmd_word
);

  logic after_cr;
  logic accept;
  logic drop;
  hrlp_pkg::cmd_t cmd;

  assign full = cmd_full;
  assign accept = push && !cmd_full;
  // Swallow the LF that directly follows a CR.
  assign drop = after_cr && (data_byte == hrlp_pkg::CH_LF);
  assign cmd_push = accept && !drop;

  always_comb begin
    cmd.data = data_byte;
    cmd.term = (data_byte == hrlp_pkg::CH_CR) || (data_byte == hrlp_pkg::CH_LF);
    cmd.sep = (data_byte == hrlp_pkg::CH_SPACE) || (data_byte == hrlp_pkg::CH_NUL) ||
              ((data_byte >= hrlp_pkg::CH_TAB) && (data_byte <= hrlp_pkg::CH_CR));
  end

  assign cmd_word = {{(hrlp_pkg::WORD_W - hrlp_pkg::CMD_W){1'b0}}, cmd};

  always_ff @(posedge clk) begin
    if (rst) begin
      after_cr <= 1'b0;
    end else if (accept) begin
      after_cr <= (data_byte == hrlp_pkg::CH_CR);
    end
  end

endmodule

### hdl/hrlp_back.sv
module hrlp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  hrlp_pkg::word_t      cmd_word,
  input  hrlp_pkg::fifo_stat_t cmd_stat,
  output logic                 cmd_pop,
  input  hrlp_pkg::fifo_stat_t res_stat,
  output logic                 res_push,
  output hrlp_pkg::word_t      res_word
);

  localparam int LW = hrlp_pkg::LINE_W;
  localparam logic [2:0] POS_MAX = 3'd5;

  hrlp_pkg::phase_t phase, phase_next;
  logic [LW-1:0] line_count, line_count_next;
  logic [1:0] field_number, field_number_next;
  logic [2:0] method_position, method_position_next;
  logic [2:0] method_candidates, method_candidates_next;
  hrlp_pkg::method_t method_code, method_code_next;
  logic in_query, in_query_next;
  logic query_seen, query_seen_next;

  hrlp_pkg::cmd_t cmd;
  hrlp_pkg::result_t res;
  logic go;
  logic [LW-1:0] line_inc;
  logic cut;
  logic [7:0] upper;

  function automatic logic [7:0] get_char(input logic [2:0] p);
    case (p)
      3'd0:    get_char = 8'h47;
      3'd1:    get_char = 8'h45;
      default: get_char = 8'h54;
    endcase
  endfunction

  function automatic logic [7:0] post_char(input logic [2:0] p);
    case (p)
      3'd0:    post_char = 8'h50;
      3'd1:    post_char = 8'h4F;
      3'd2:    post_char = 8'h53;
      default: post_char = 8'h54;
    endcase
  endfunction

  function automatic logic [7:0] head_char(input logic [2:0] p);
    case (p)
      3'd0:    head_char = 8'h48;
      3'd1:    head_char = 8'h45;
      3'd2:    head_char = 8'h41;
      default: head_char = 8'h44;
    endcase
  endfunction

  function automatic hrlp_pkg::method_t method_close(input logic [2:0] p,
                                                     input logic [2:0] cand);
    if (p == 3'd3 && cand[0]) begin
      method_close = hrlp_pkg::METHOD_GET;
    end else if (p == 3'd4 && cand[1]) begin
      method_close = hrlp_pkg::METHOD_POST;
    end else if (p == 3'd4 && cand[2]) begin
      method_close = hrlp_pkg::METHOD_HEAD;
    end else begin
      method_close = hrlp_pkg::METHOD_NONE;
    end
  endfunction

  assign cmd = hrlp_pkg::cmd_t'(cmd_word[hrlp_pkg::CMD_W-1:0]);
  assign go = !cmd_stat.empty && !res_stat.full;
  assign cmd_pop = go;
  assign line_inc = line_count + 1'b1;
  // Line cut at the length limit closes the line just like a terminator.
  assign cut = !cmd.term && (line_inc >= LW'(hrlp_pkg::LINE_LIMIT - 1));
  assign upper = (cmd.data >= 8'h61 && cmd.data <= 8'h7A) ? (cmd.data - 8'h20) : cmd.data;
  assign res_word = res;

  always_comb begin
    phase_next = phase;
    if (go) begin
      unique case (phase)
        hrlp_pkg::PH_REQUEST: begin
          if (cmd.term || cut) begin
            phase_next = hrlp_pkg::PH_HEADER;
          end
        end
        hrlp_pkg::PH_HEADER: begin
          if (cmd.term && line_count == '0) begin
            phase_next = hrlp_pkg::PH_REQUEST;
          end
        end
        default: phase_next = phase;
      endcase
    end
  end

  always_comb begin
    line_count_next = line_count;
    field_number_next = field_number;
    method_position_next = method_position;
    method_candidates_next = method_candidates;
    method_code_next = method_code;
    in_query_next = in_query;
    query_seen_next = query_seen;
    res_push = 1'b0;
    res.kind = hrlp_pkg::KIND_PATH;
    res.out_byte = cmd.data;
    res.status = hrlp_pkg::STATUS_OK;
    res.method = method_code;
    res.has_query = 1'b0;

    if (go) begin
      if (cmd.term) begin
        line_count_next = '0;
        if (phase == hrlp_pkg::PH_REQUEST) begin
          if (field_number == 2'd0) begin
            method_code_next = method_close(method_position, method_candidates);
          end
        end else if (line_count == '0) begin
          // Empty header line: report and start over.
          res_push = 1'b1;
          res.kind = hrlp_pkg::KIND_DONE;
          res.out_byte = 8'h00;
          res.status = (method_code == hrlp_pkg::METHOD_NONE) ? hrlp_pkg::STATUS_NOT_IMPL
                       : hrlp_pkg::STATUS_OK;
          res.has_query = query_seen;
          field_number_next = 2'd0;
          method_position_next = 3'd0;
          method_candidates_next = 3'b111;
          method_code_next = hrlp_pkg::METHOD_NONE;
          in_query_next = 1'b0;
          query_seen_next = 1'b0;
        end
      end else begin
        if (phase == hrlp_pkg::PH_REQUEST) begin
          if (cmd.sep) begin
            if (field_number == 2'd0) begin
              method_code_next = method_close(method_position, method_candidates);
            end
            if (field_number != 2'd3) begin
              field_number_next = field_number + 1'b1;
            end
          end else if (field_number == 2'd0) begin
            if (method_position >= 3'd3 || get_char(method_position) != upper) begin
              method_candidates_next[0] = 1'b0;
            end
            if (method_position >= 3'd4 || post_char(method_position) != upper) begin
              method_candidates_next[1] = 1'b0;
            end
            if (method_position >= 3'd4 || head_char(method_position) != upper) begin
              method_candidates_next[2] = 1'b0;
            end
            if (method_position < POS_MAX) begin
              method_position_next = method_position + 1'b1;
            end
          end else if (method_code != hrlp_pkg::METHOD_NONE && field_number != 2'd3) begin
            res_push = 1'b1;
            res.kind = hrlp_pkg::KIND_VERSION;
            if (field_number == 2'd1) begin
              if (!in_query && cmd.data == hrlp_pkg::CH_QMARK) begin
                // Drop the first question mark, switch to query bytes.
                in_query_next = 1'b1;
                query_seen_next = 1'b1;
                res_push = 1'b0;
              end
              res.kind = (in_query || cmd.data == hrlp_pkg::CH_QMARK) ?
                         hrlp_pkg::KIND_QUERY : hrlp_pkg::KIND_PATH;
            end
          end
        end
        if (cut) begin
          line_count_next = '0;
          if (phase == hrlp_pkg::PH_REQUEST && field_number_next == 2'd0) begin
            method_code_next = method_close(method_position_next, method_candidates_next);
          end
        end else begin
          line_count_next = line_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= hrlp_pkg::PH_REQUEST;
      line_count <= '0;
      field_number <= 2'd0;
      method_position <= 3'd0;
      method_candidates <= 3'b111;
      method_code <= hrlp_pkg::METHOD_NONE;
      in_query <= 1'b0;
      query_seen <= 1'b0;
    end else begin
      phase <= phase_next;
      line_count <= line_count_next;
      field_number <= field_number_next;
      method_position <= method_position_next;
      method_candidates <= method_candidates_next;
      method_code <= method_code_next;
      in_query <= in_query_next;
      query_seen <= query_seen_next;
    end
  end

endmodule

### hdl/http_request_line_parser.sv
// Path: a byte accepted on push is written to the command queue, parsed by the back part, and its
// result is registered into the result queue, from which it can be popped.
// Throughput: one byte per cycle while neither queue backs up, set by the parse step in the back part.
// Two-entry queues sit after the classifier and after the parser.
// Reset (rst, synchronous, active high): queues empty, parser back on the request line.
`include "http_request_line_parser_macros.svh"

module http_request_line_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] data_byte,
  input  logic       push,
  output logic       full,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind,
  output logic [7:0] out_byte,
  output logic       status,
  output logic [1:0] method,
  output logic       has_query
);

  logic cmd_push;
  logic cmd_pop;
  logic res_push;
  hrlp_pkg::word_t cmd_in;
  hrlp_pkg::word_t cmd_out;
  hrlp_pkg::word_t res_in;
  hrlp_pkg::word_t res_out;
  hrlp_pkg::fifo_stat_t cmd_stat;
  hrlp_pkg::fifo_stat_t res_stat;
  hrlp_pkg::result_t res;
  logic done_beat;
  logic byte_beat;
  logic no_method;

  hrlp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .data_byte (data_byte),
    .push      (push),
    .full      (full),
    .cmd_full  (cmd_stat.full),
    .cmd_push  (cmd_push),
    .cmd_word  (cmd_in)
  );

  hrlp_fifo u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .wr_data (cmd_in),
    .pop     (cmd_pop),
    .rd_data (cmd_out),
    .stat    (cmd_stat)
  );

  hrlp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_word (cmd_out),
    .cmd_stat (cmd_stat),
    .cmd_pop  (cmd_pop),
    .res_stat (res_stat),
    .res_push (res_push),
    .res_word (res_in)
  );

  hrlp_fifo u_res_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_in),
    .pop     (pop),
    .rd_data (res_out),
    .stat    (res_stat)
  );

  assign res = hrlp_pkg::result_t'(res_out);
  assign empty = res_stat.empty;
  assign kind = res.kind;
  assign out_byte = res.out_byte;
  assign status = res.status;
  assign method = res.method;
  assign has_query = res.has_query;

  assign done_beat = !empty && (kind == hrlp_pkg::KIND_DONE);
  assign byte_beat = !empty && (kind != hrlp_pkg::KIND_DONE);
  assign no_method = (method == hrlp_pkg::METHOD_NONE);

  `HRLP_ASSERT_IMPLIES(a_done_byte_zero, clk, rst, done_beat, out_byte == 8'h00)
  `HRLP_ASSERT_IMPLIES(a_done_status, clk, rst, done_beat, status == no_method)
  `HRLP_ASSERT_IMPLIES(a_byte_has_method, clk, rst, byte_beat, !no_method && !status && !has_query)
  `HRLP_ASSERT_NEXT(a_result_held, clk, rst, !empty && !pop, !empty)

endmodule

### sim/tb_top.sv
module tb_top;
  import hrlp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_BYTES = 1800;
  localparam int LONG_LEN = 1030;
  localparam int HOLD_CYCLES = 600;
  localparam int HOLD_AFTER = 60;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_GAP = 16;

  // Method candidate bits
  localparam int C_GET = 0;
  localparam int C_POST = 1;
  localparam int C_HEAD = 2;

  localparam logic [31:0] WORD_GET = {"GET", 8'h00};
  localparam logic [31:0] WORD_POST = "POST";
  localparam logic [31:0] WORD_HEAD = "HEAD";

  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  localparam result_t NO_RES = '0;

  typedef struct packed {
    logic [7:0] b;
    logic typed;
    logic has;
    result_t res;
  } dir_row_t;

  localparam int DIR_ROWS = 27;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{"G", 1'b1, 1'b0, NO_RES},
    '{"e", 1'b1, 1'b0, NO_RES},
    '{"T", 1'b1, 1'b0, NO_RES},
    '{CH_SPACE, 1'b0, 1'b0, NO_RES},
    '{"/", 1'b0, 1'b0, NO_RES},
    '{CH_QMARK, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b1, 1'b1, '{KIND_QUERY, 8'hFF, STATUS_OK, METHOD_GET, 1'b0}},
    '{CH_SPACE, 1'b0, 1'b0, NO_RES},
    '{"1", 1'b0, 1'b0, NO_RES},
    '{CH_LF, 1'b0, 1'b0, NO_RES},
    '{CH_LF, 1'b1, 1'b1, '{KIND_DONE, 8'h00, STATUS_OK, METHOD_GET, 1'b1}},
    // empty request line, then an empty header line
    '{CH_CR, 1'b1, 1'b0, NO_RES},
    '{CH_LF, 1'b1, 1'b0, NO_RES},
    '{CH_CR, 1'b1, 1'b1, '{KIND_DONE, 8'h00, STATUS_NOT_IMPL, METHOD_NONE, 1'b0}},
    '{CH_LF, 1'b1, 1'b0, NO_RES},
    // odd separators, empty path, dropped fourth field
    '{"h", 1'b0, 1'b0, NO_RES},
    '{"E", 1'b0, 1'b0, NO_RES},
    '{"A", 1'b0, 1'b0, NO_RES},
    '{"D", 1'b0, 1'b0, NO_RES},
    '{CH_TAB, 1'b0, 1'b0, NO_RES},
    '{CH_NUL, 1'b0, 1'b0, NO_RES},
    '{"a", 1'b0, 1'b0, NO_RES},
    '{CH_VT, 1'b0, 1'b0, NO_RES},
    '{CH_FF, 1'b0, 1'b0, NO_RES},
    '{"z", 1'b0, 1'b0, NO_RES},
    '{CH_CR, 1'b0, 1'b0, NO_RES},
    '{CH_CR, 1'b1, 1'b1, '{KIND_DONE, 8'h00, STATUS_OK, METHOD_HEAD, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [7:0] data_byte = 8'h00;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic status;
  logic [1:0] method;
  logic has_query;

  http_request_line_parser u_dut (
    .clk(clk),
    .rst(rst),
    .data_byte(data_byte),
    .push(push),
    .full(full),
    .empty(empty),
    .pop(pop),
    .kind(kind),
    .out_byte(out_byte),
    .status(status),
    .method(method),
    .has_query(has_query)
  );

  // Parser shadow state
  phase_t ph;
  logic after_cr;
  int unsigned line_cnt;
  logic [1:0] fld;
  logic [2:0] mpos;
  logic [2:0] cand;
  method_t mcode;
  logic in_q;
  logic q_seen;

  result_t pending_results[$];
  logic [7:0] req_q[$];
  int errors = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  logic send_calm = 1'b0;
  logic recv_calm = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic is_blank(input logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR) || b == CH_NUL;
  endfunction

  task automatic clear_request();
    ph = PH_REQUEST;
    line_cnt = 0;
    fld = 2'd0;
    mpos = 3'd0;
    cand = 3'b111;
    mcode = METHOD_NONE;
    in_q = 1'b0;
    q_seen = 1'b0;
  endtask

  task automatic take_method_char(input logic [7:0] b);
    logic [7:0] u;
    int p;
    u = (b >= "a" && b <= "z") ? b - 8'd32 : b;
    p = mpos;
    if (p >= 3 || WORD_GET[31-8*p -: 8] != u) cand[C_GET] = 1'b0;
    if (p >= 4 || WORD_POST[31-8*p -: 8] != u) cand[C_POST] = 1'b0;
    if (p >= 4 || WORD_HEAD[31-8*p -: 8] != u) cand[C_HEAD] = 1'b0;
    if (mpos < 3'd5) mpos++;
  endtask

  task automatic settle_method();
    mcode = METHOD_NONE;
    if (mpos == 3'd3 && cand[C_GET]) mcode = METHOD_GET;
    else if (mpos == 3'd4 && cand[C_POST]) mcode = METHOD_POST;
    else if (mpos == 3'd4 && cand[C_HEAD]) mcode = METHOD_HEAD;
  endtask

  task automatic close_field();
    if (fld == 2'd0) settle_method();
    if (fld < 2'd3) fld++;
  endtask

  task automatic end_request_line();
    if (fld == 2'd0) settle_method();
    ph = PH_HEADER;
    line_cnt = 0;
  endtask

  task automatic parse_byte(input logic [7:0] b, output logic got, output result_t r);
    logic term;
    got = 1'b0;
    r = NO_RES;
    term = 1'b0;
    if (after_cr) begin
      after_cr = 1'b0;
      // swallow the LF of a CR LF pair
      if (b == CH_LF) return;
    end
    if (b == CH_CR) begin
      after_cr = 1'b1;
      term = 1'b1;
    end else if (b == CH_LF) begin
      term = 1'b1;
    end
    if (term) begin
      if (ph == PH_REQUEST) begin
        end_request_line();
      end else if (line_cnt == 0) begin
        got = 1'b1;
        r.kind = KIND_DONE;
        r.out_byte = 8'h00;
        r.status = (mcode == METHOD_NONE) ? STATUS_NOT_IMPL : STATUS_OK;
        r.method = mcode;
        r.has_query = q_seen;
        clear_request();
      end else begin
        line_cnt = 0;
      end
      return;
    end
    if (ph == PH_REQUEST) begin
      if (is_blank(b)) begin
        close_field();
      end else if (fld == 2'd0) begin
        take_method_char(b);
      end else if (mcode != METHOD_NONE && fld <= 2'd2) begin
        got = 1'b1;
        r.kind = KIND_VERSION;
        if (fld == 2'd1) begin
          // the first '?' opens the query and is not emitted
          if (!in_q && b == CH_QMARK) begin
            in_q = 1'b1;
            q_seen = 1'b1;
            got = 1'b0;
          end
          r.kind = in_q ? KIND_QUERY : KIND_PATH;
        end
        r.out_byte = b;
        r.method = mcode;
        if (!got) r = NO_RES;
      end
    end
    line_cnt++;
    // cut an overlong line
    if (line_cnt >= LINE_LIMIT - 1) begin
      if (ph == PH_REQUEST) end_request_line();
      else line_cnt = 0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic check_result();
    result_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected beat kind %0d byte %02h", kind, out_byte));
      return;
    end
    want = pending_results.pop_front();
    compare_field("kind", kind, want.kind);
    compare_field("out_byte", out_byte, want.out_byte);
    compare_field("status", status, want.status);
    compare_field("method", method, want.method);
    compare_field("has_query", has_query, want.has_query);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic typed, input logic has,
                           input result_t res);
    logic got;
    result_t r;
    int gap;
    push <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (full);
    parse_byte(b, got, r);
    if (typed) begin
      got = has;
      r = res;
    end
    if (got) pending_results.push_back(r);
    bytes_sent++;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] field_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_blank(b));
    return b;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 7))
      5: return CH_TAB;
      6: return CH_NUL;
      7: return $urandom_range(0, 1) ? CH_VT : CH_FF;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] any_case(input logic [7:0] c);
    return $urandom_range(0, 1) ? (c | 8'h20) : c;
  endfunction

  task automatic add_line_end();
    case ($urandom_range(0, 3))
      0: req_q.push_back(CH_CR);
      1: req_q.push_back(CH_LF);
      default: begin
        req_q.push_back(CH_CR);
        req_q.push_back(CH_LF);
      end
    endcase
  endtask

  task automatic add_method();
    string w;
    int n;
    int mode;
    case ($urandom_range(0, 2))
      0: w = "GET";
      1: w = "POST";
      default: w = "HEAD";
    endcase
    n = w.len();
    mode = $urandom_range(0, 9);
    if (mode == 7) n--;
    if (mode == 9) begin
      repeat ($urandom_range(1, 6)) req_q.push_back(any_case(8'("A" + $urandom_range(0, 25))));
    end else begin
      for (int i = 0; i < n; i++) req_q.push_back(any_case(w[i]));
    end
    if (mode == 8) req_q.push_back(any_case(8'("A" + $urandom_range(0, 25))));
  endtask

  task automatic build_request(input int idx);
    string v;
    int len;
    int nhdr;
    logic [7:0] b;
    req_q.delete();
    // line noise ahead of the request
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 16)) req_q.push_back(8'($urandom_range(0, 255)));
    end
    add_method();
    req_q.push_back(blank_char());
    if ($urandom_range(0, 7) == 0) req_q.push_back(blank_char());
    req_q.push_back("/");
    len = (idx == 2) ? LONG_LEN : $urandom_range(0, 12);
    repeat (len) req_q.push_back($urandom_range(0, 5) == 0 ? CH_QMARK : field_char());
    if ($urandom_range(0, 5) != 0) begin
      req_q.push_back(blank_char());
      if ($urandom_range(0, 3) != 0) begin
        v = "HTTP/1.1";
        for (int i = 0; i < v.len(); i++) req_q.push_back(v[i]);
      end else begin
        repeat ($urandom_range(1, 8)) req_q.push_back(field_char());
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      req_q.push_back(blank_char());
      repeat ($urandom_range(1, 5)) req_q.push_back(field_char());
    end
    add_line_end();
    nhdr = $urandom_range(0, 3);
    if (idx == 4) nhdr++;
    for (int h = 0; h < nhdr; h++) begin
      len = (idx == 4 && h == 0) ? LONG_LEN : $urandom_range(1, 20);
      repeat (len) begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
        req_q.push_back(b);
      end
      add_line_end();
    end
    // leave a few requests open
    if ($urandom_range(0, 19) != 0) add_line_end();
  endtask

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk) cycles++;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int gap;
    logic held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      // hold off the drain long enough to back up the input
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
      gap = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      check_result();
    end
  end

  initial begin
    int req_idx;
    after_cr = 1'b0;
    clear_request();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_byte(DIR_TAB[i].b, DIR_TAB[i].typed, DIR_TAB[i].has, DIR_TAB[i].res);
    end
    wait_drained();
    req_idx = 0;
    while (bytes_sent < RAND_BYTES || req_idx < 8) begin
      build_request(req_idx);
      foreach (req_q[i]) send_byte(req_q[i], 1'b0, 1'b0, NO_RES);
      if (req_idx == 6) wait_drained();
      req_idx++;
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/hrlp_pkg.sv
hdl/hrlp_fifo.sv
hdl/hrlp_front.sv
hdl/hrlp_back.sv
hdl/http_request_line_parser.sv
sim/tb_top.sv
